/* rtl/sphere_light_top_k_selector_macros.svh */
// Assertion helpers used by the checker file sltks_chk.sv.
`ifndef SPHERE_LIGHT_TOP_K_SELECTOR_MACROS_SVH
`define SPHERE_LIGHT_TOP_K_SELECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SLTKS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sltks check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SLTKS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sltks check failed");

`endif

/* rtl/sltks_pkg.sv */
package sltks_pkg;

	localparam int MAX_SLOTS = 8;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	localparam int IN_DATA_W  = 216;
	localparam int OUT_DATA_W = 96;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_OFFER = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [2:0] KIND_CLEARED  = 3'd0;
	localparam logic [2:0] KIND_APPENDED = 3'd1;
	localparam logic [2:0] KIND_REPLACED = 3'd2;
	localparam logic [2:0] KIND_SKIPPED  = 3'd3;
	localparam logic [2:0] KIND_DIM      = 3'd4;
	localparam logic [2:0] KIND_READ     = 3'd5;

	localparam logic [2:0] REG_QUERY_X      = 3'd0;
	localparam logic [2:0] REG_QUERY_Y      = 3'd1;
	localparam logic [2:0] REG_QUERY_Z      = 3'd2;
	localparam logic [2:0] REG_QUERY_RADIUS = 3'd3;
	localparam logic [2:0] REG_QUERY_OBJECT = 3'd4;
	localparam logic [2:0] REG_MAX_SLOTS    = 3'd5;

	localparam logic signed [17:0] FALL_MIN = -18'sd131072;

	typedef struct packed {
		logic [31:0] light_id;
		logic [31:0] prio;
		logic [17:0] falloff;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/sphere_light_top_k_selector.sv */
// An offer squares deltas and radii on the shared multiplier, runs an 18-step
// divide for the falloff if needed, and scans the slots when the table is full.
// One item in flight; the next beat is taken once the result sits in the
// output register. Throughput is set by the shared 32x32 multiplier, the
// radix-2 divider and the single read port of the slot table.
// Reset (arst_n low, async): table empty, query regs 0, max_slots 8.
module sphere_light_top_k_selector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [2:0]                           cfg_addr,
	input  logic [31:0]                          cfg_data,
	// input beats
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// light_id[31:0], light_pos_x[63:32], light_pos_y[95:64], light_pos_z[127:96],
	// lamp_rad[158:128], lamp_bright[174:159], light_enabled[175],
	// light_owner[207:176], no_self_light[208], already_visited[209],
	// slot_select[212:210], zero pad
	input  logic [sltks_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// command[1:0]
	input  logic [1:0]                           s_axis_tuser,
	// result beats
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// slot_index[2:0], light_total[6:3], entry_light_id[38:7],
	// entry_priority[70:39], entry_falloff[88:71], zero pad
	output logic [sltks_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// result_kind[2:0]
	output logic [2:0]                           m_axis_tuser
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_RDWAIT   = 4'd1;
	localparam logic [3:0] S_MUL      = 4'd2;
	localparam logic [3:0] S_CHK      = 4'd3;
	localparam logic [3:0] S_DIV      = 4'd4;
	localparam logic [3:0] S_PRIO     = 4'd5;
	localparam logic [3:0] S_PLACE    = 4'd6;
	localparam logic [3:0] S_SCAN_RD  = 4'd7;
	localparam logic [3:0] S_SCAN_CMP = 4'd8;
	localparam logic [3:0] S_SEL      = 4'd9;
	localparam logic [3:0] S_DONE     = 4'd10;

	localparam int SW = sltks_pkg::SLOT_W;
	localparam int CW = sltks_pkg::CNT_W;

	logic [3:0] state_q;

	// config
	logic signed [31:0] qx_q, qy_q, qz_q;
	logic [30:0]        qrad_q;
	logic [31:0]        qobj_q;
	logic [3:0]         max_slots_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] limit;

	// input field views
	logic [31:0]        in_id;
	logic signed [31:0] in_x, in_y, in_z;
	logic [30:0]        in_rad;
	logic [15:0]        in_bright;
	logic               in_en, in_nsl, in_vis;
	logic [31:0]        in_owner;
	logic [SW-1:0]      in_sel;

	// working regs
	logic [31:0]        id_q;
	logic [15:0]        bright_q;
	logic [31:0]        adx_q, ady_q, adz_q;
	logic [31:0]        rs_q;
	logic [30:0]        lr_q;
	logic [SW-1:0]      sel_q;
	logic [2:0]         mcnt_q;
	logic [63:0]        prod_q;
	logic [63:0]        d2_q;
	logic [63:0]        rs2_q;
	logic [61:0]        lr2_q;
	logic [63:0]        rem_q;
	logic [17:0]        quo_q;
	logic [4:0]         dcnt_q;
	logic signed [17:0] fall_q;
	logic signed [34:0] pprod_q;
	logic signed [31:0] prio_q;
	logic signed [31:0] minp_q;
	logic [SW-1:0]      dim_q;
	logic [SW-1:0]      scnt_q;

	// pending result
	logic [2:0]  res_kind_q;
	logic [SW-1:0] res_slot_q;
	logic [31:0] res_id_q;
	logic [31:0] res_prio_q;
	logic [17:0] res_fall_q;

	// output register
	logic                         out_valid_q;
	logic [sltks_pkg::OUT_DATA_W-1:0] out_data_q;
	logic [2:0]                   out_kind_q;

	// table memory
	logic                      ram_we;
	logic [SW-1:0]             ram_waddr, ram_raddr;
	sltks_pkg::entry_t         ram_wdata, ram_rdata;

	sltks_ram #(
		.WIDTH (sltks_pkg::ENTRY_W),
		.DEPTH (sltks_pkg::MAX_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_id     = s_axis_tdata[31:0];
	assign in_x      = s_axis_tdata[63:32];
	assign in_y      = s_axis_tdata[95:64];
	assign in_z      = s_axis_tdata[127:96];
	assign in_rad    = s_axis_tdata[158:128];
	assign in_bright = s_axis_tdata[174:159];
	assign in_en     = s_axis_tdata[175];
	assign in_owner  = s_axis_tdata[207:176];
	assign in_nsl    = s_axis_tdata[208];
	assign in_vis    = s_axis_tdata[209];
	assign in_sel    = s_axis_tdata[210 +: SW];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

	assign limit = (max_slots_q > CW'(sltks_pkg::MAX_SLOTS)) ?
		CW'(sltks_pkg::MAX_SLOTS) : CW'(max_slots_q);

	// exact 33-bit deltas, magnitude fits 32 bits
	logic signed [32:0] dx, dy, dz;
	logic [32:0]        ndx, ndy, ndz;
	assign dx  = {qx_q[31], qx_q} - {in_x[31], in_x};
	assign dy  = {qy_q[31], qy_q} - {in_y[31], in_y};
	assign dz  = {qz_q[31], qz_q} - {in_z[31], in_z};
	assign ndx = -dx;
	assign ndy = -dy;
	assign ndz = -dz;

	logic skip;
	assign skip = !in_en || in_vis || ((in_owner == qobj_q) && in_nsl);

	// shared multiplier operand select
	logic [31:0] mul_a;
	always_comb begin
		case (mcnt_q)
			3'd0:    mul_a = adx_q;
			3'd1:    mul_a = ady_q;
			3'd2:    mul_a = adz_q;
			3'd3:    mul_a = rs_q;
			3'd4:    mul_a = {1'b0, lr_q};
			default: mul_a = '0;
		endcase
	end

	// saturating accumulate of squared deltas
	logic [64:0] acc_sum;
	logic [63:0] acc_sat;
	assign acc_sum = {1'b0, d2_q} + {1'b0, prod_q};
	assign acc_sat = acc_sum[64] ? '1 : acc_sum[63:0];

	logic [63:0] lr2_x3;
	assign lr2_x3 = {1'b0, lr2_q, 1'b0} + {2'b0, lr2_q};

	// restoring divide step; first two steps give the integer part
	logic [63:0] div_rr;
	logic [63:0] div_dv;
	logic        div_ge;
	logic [17:0] quo_n;
	assign div_rr = (dcnt_q < 5'd2) ? rem_q : {rem_q[62:0], 1'b0};
	assign div_dv = (dcnt_q == 5'd0) ? {1'b0, lr2_q, 1'b0} : {2'b0, lr2_q};
	assign div_ge = (div_rr >= div_dv);
	assign quo_n  = {quo_q[16:0], div_ge};

	// floor(brightness * falloff / 4096), always within 32 bits
	logic signed [34:0] prio_sh;
	logic signed [31:0] prio_w;
	assign prio_sh = pprod_q >>> 12;
	assign prio_w  = prio_sh[31:0];

	logic signed [31:0] rd_prio;
	assign rd_prio = ram_rdata.prio;

	assign ram_raddr = (state_q == S_SCAN_RD) ? scnt_q : in_sel;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[SW-1:0];
		ram_wdata.light_id = id_q;
		ram_wdata.prio     = prio_w;
		ram_wdata.falloff  = fall_q;
		if (state_q == S_PLACE) begin
			ram_we = (count_q < limit);
		end else if (state_q == S_SEL) begin
			ram_wdata.prio = prio_q;
			ram_waddr      = dim_q;
			ram_we         = (minp_q < prio_q) && ({1'b0, dim_q} < limit);
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q        <= '0;
			qy_q        <= '0;
			qz_q        <= '0;
			qrad_q      <= '0;
			qobj_q      <= '0;
			max_slots_q <= 4'd8;
		end else if (cfg_valid) begin
			case (cfg_addr)
				sltks_pkg::REG_QUERY_X:      qx_q        <= cfg_data;
				sltks_pkg::REG_QUERY_Y:      qy_q        <= cfg_data;
				sltks_pkg::REG_QUERY_Z:      qz_q        <= cfg_data;
				sltks_pkg::REG_QUERY_RADIUS: qrad_q      <= cfg_data[30:0];
				sltks_pkg::REG_QUERY_OBJECT: qobj_q      <= cfg_data;
				sltks_pkg::REG_MAX_SLOTS:    max_slots_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// S_DONE reloads the output register itself
			if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						if (s_axis_tuser == sltks_pkg::CMD_CLEAR) begin
							count_q <= '0;
							state_q <= S_DONE;
						end else if (s_axis_tuser == sltks_pkg::CMD_READ) begin
							state_q <= S_RDWAIT;
						end else if (s_axis_tuser == sltks_pkg::CMD_OFFER && !skip) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_RDWAIT: state_q <= S_DONE;
				S_MUL: begin
					if (mcnt_q == 3'd5) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (!(d2_q < rs2_q)) begin
						state_q <= S_DONE;
					end else if (lr2_q == '0 || d2_q >= lr2_x3) begin
						state_q <= S_PRIO;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dcnt_q == 5'd17) begin
						state_q <= S_PRIO;
					end
				end
				S_PRIO: state_q <= S_PLACE;
				S_PLACE: begin
					if (count_q < limit) begin
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end else if (count_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CMP;
				S_SCAN_CMP: begin
					if ({1'b0, scnt_q} + 1'b1 == count_q) begin
						state_q <= S_SEL;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SEL: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_a;
		case (state_q)
			S_IDLE: begin
				id_q       <= in_id;
				bright_q   <= in_bright;
				sel_q      <= in_sel;
				adx_q      <= dx[32] ? ndx[31:0] : dx[31:0];
				ady_q      <= dy[32] ? ndy[31:0] : dy[31:0];
				adz_q      <= dz[32] ? ndz[31:0] : dz[31:0];
				rs_q       <= {1'b0, in_rad} + {1'b0, qrad_q};
				lr_q       <= in_rad;
				mcnt_q     <= '0;
				res_kind_q <= (s_axis_tuser == sltks_pkg::CMD_CLEAR) ?
					sltks_pkg::KIND_CLEARED : sltks_pkg::KIND_SKIPPED;
				res_slot_q <= '0;
				res_id_q   <= '0;
				res_prio_q <= '0;
				res_fall_q <= '0;
			end
			S_RDWAIT: begin
				res_kind_q <= sltks_pkg::KIND_READ;
				res_slot_q <= sel_q;
				res_id_q   <= ram_rdata.light_id;
				res_prio_q <= ram_rdata.prio;
				res_fall_q <= ram_rdata.falloff;
			end
			S_MUL: begin
				mcnt_q <= mcnt_q + 1'b1;
				case (mcnt_q)
					3'd1:    d2_q  <= prod_q;
					3'd2:    d2_q  <= acc_sat;
					3'd3:    d2_q  <= acc_sat;
					3'd4:    rs2_q <= prod_q;
					3'd5:    lr2_q <= prod_q[61:0];
					default: ;
				endcase
			end
			S_CHK: begin
				fall_q <= sltks_pkg::FALL_MIN;
				rem_q  <= d2_q;
				quo_q  <= '0;
				dcnt_q <= '0;
			end
			S_DIV: begin
				dcnt_q <= dcnt_q + 1'b1;
				quo_q  <= quo_n;
				rem_q  <= div_ge ? (div_rr - div_dv) : div_rr;
				if (dcnt_q == 5'd17) begin
					fall_q <= 18'(19'd65536 - {1'b0, quo_n});
				end
			end
			S_PRIO: begin
				pprod_q <= $signed({1'b0, bright_q}) * fall_q;
			end
			S_PLACE: begin
				prio_q <= prio_w;
				scnt_q <= '0;
				if (count_q < limit) begin
					res_kind_q <= sltks_pkg::KIND_APPENDED;
					res_slot_q <= count_q[SW-1:0];
					res_id_q   <= id_q;
					res_prio_q <= prio_w;
					res_fall_q <= fall_q;
				end else begin
					res_kind_q <= sltks_pkg::KIND_DIM;
				end
			end
			S_SCAN_CMP: begin
				scnt_q <= scnt_q + 1'b1;
				if (scnt_q == '0 || rd_prio < minp_q) begin
					minp_q <= rd_prio;
					dim_q  <= scnt_q;
				end
			end
			S_SEL: begin
				if (ram_we) begin
					res_kind_q <= sltks_pkg::KIND_REPLACED;
					res_slot_q <= dim_q;
					res_id_q   <= id_q;
					res_prio_q <= prio_q;
					res_fall_q <= fall_q;
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_kind_q <= res_kind_q;
					out_data_q <= {7'd0, res_fall_q, res_prio_q, res_id_q,
						4'(count_q), 3'(res_slot_q)};
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/sltks_ram.sv */
module sltks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/sltks_chk.sv */
`include "sphere_light_top_k_selector_macros.svh"

module sltks_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [sltks_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [2:0]                       m_axis_tuser
);

	`SLTKS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`SLTKS_ASSERT_NOW(a_clear_empty, m_axis_tvalid && m_axis_tuser == sltks_pkg::KIND_CLEARED, m_axis_tdata[6:3] == 4'd0)
	`SLTKS_ASSERT_NOW(a_total_max, m_axis_tvalid, m_axis_tdata[6:3] <= 4'(sltks_pkg::MAX_SLOTS))
	`SLTKS_ASSERT_NOW(a_reject_zero, m_axis_tvalid && (m_axis_tuser == sltks_pkg::KIND_SKIPPED || m_axis_tuser == sltks_pkg::KIND_DIM), m_axis_tdata[88:7] == '0 && m_axis_tdata[2:0] == 3'd0)

endmodule

bind sphere_light_top_k_selector sltks_chk u_sltks_chk (.*);

/* bench/testbench.sv */
`timescale 1ns / 100ps

// Light table selector bench.
// Fill process: builds a queue of beats, phase by phase. Each beat runs
// through the local model of the light table when it is queued; it is
// accepted in order, so the expected result is pushed right away.
// Register writes only happen with the block drained.
// Driver: bursts and gaps at negedge. Monitor: posedge compare, in order.
module testbench;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_WAIT  = 60;     // extra wait after both queues are empty
	localparam logic [1:0] CMD_BAD = 2'd3;  // unknown command

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] id;
		logic [31:0] px, py, pz;
		logic [30:0] radius;
		logic [15:0] bright;
		logic        enabled;
		logic [31:0] owner;
		logic        no_self;
		logic        visited;
		logic [2:0]  sel;
	} light_beat_t;

	typedef struct {
		logic [2:0]  kind;
		logic [2:0]  slot;
		logic [3:0]  total;
		logic [31:0] id;
		logic [31:0] prio;
		logic [17:0] fall;
	} light_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_addr = '0;
	logic [31:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [sltks_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [sltks_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;

	sphere_light_top_k_selector i_dut (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_addr, .cfg_data,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the block: query regs and the light table
	logic [31:0] q_x, q_y, q_z, q_obj;
	logic [30:0] q_rad;
	logic [3:0]  q_slots;
	logic [31:0] tbl_id [sltks_pkg::MAX_SLOTS];
	logic [31:0] tbl_prio [sltks_pkg::MAX_SLOTS];
	logic [17:0] tbl_fall [sltks_pkg::MAX_SLOTS];
	int unsigned tbl_count;
	logic [sltks_pkg::MAX_SLOTS-1:0] slot_written;  // never cleared; reads stay on written slots

	light_beat_t   pending_beats[$];
	light_result_t expected_results[$];
	int mismatches = 0;
	bit long_stall_go = 1'b0;

	function automatic longint unsigned axis_sq(logic [31:0] a, logic [31:0] b);
		logic signed [32:0] d;
		longint unsigned m;
		d = $signed({a[31], a}) - $signed({b[31], b});
		m = d < 0 ? longint'(-d) : longint'(d);
		return m * m;
	endfunction

	function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	// Runs one beat through the table model; returns its result.
	function automatic light_result_t predict_light_result(light_beat_t b);
		light_result_t r;
		longint unsigned d2, rsum, lr2;
		logic [79:0] quot;
		int fall, prio, limit, dim, minp;
		longint p;
		r = '{kind: sltks_pkg::KIND_SKIPPED, slot: 3'd0, total: 4'd0, id: '0, prio: '0,
			fall: '0};
		limit = q_slots < sltks_pkg::MAX_SLOTS ? q_slots : sltks_pkg::MAX_SLOTS;
		if (b.cmd == sltks_pkg::CMD_CLEAR) begin
			tbl_count = 0;
			r.kind = sltks_pkg::KIND_CLEARED;
		end else if (b.cmd == sltks_pkg::CMD_READ) begin
			r.kind = sltks_pkg::KIND_READ;
			r.slot = b.sel;
			r.id   = tbl_id[b.sel];
			r.prio = tbl_prio[b.sel];
			r.fall = tbl_fall[b.sel];
		end else if (b.cmd == sltks_pkg::CMD_OFFER && b.enabled && !b.visited
				&& !(b.owner == q_obj && b.no_self)) begin
			d2 = sat_sum(sat_sum(axis_sq(q_x, b.px), axis_sq(q_y, b.py)), axis_sq(q_z, b.pz));
			rsum = longint'(b.radius) + longint'(q_rad);
			if (d2 < rsum * rsum) begin
				lr2 = longint'(b.radius) * longint'(b.radius);
				if (d2 >= 3 * lr2) begin
					fall = -131072;
				end else begin
					quot = {d2, 16'h0} / {16'h0, lr2};
					fall = 65536 - int'(quot);
				end
				p = longint'(b.bright) * longint'(fall);
				prio = int'(p >>> 12);   // floor, never saturates at these widths
				if (tbl_count < limit) begin
					dim = tbl_count;
					tbl_count++;
					r.kind = sltks_pkg::KIND_APPENDED;
				end else begin
					// first strict minimum over every stored entry
					dim = 0;
					minp = 0;
					for (int i = 0; i < tbl_count && i < sltks_pkg::MAX_SLOTS; i++)
						if (i == 0 || $signed(tbl_prio[i]) < minp) begin
							minp = $signed(tbl_prio[i]);
							dim = i;
						end
					if (tbl_count > 0 && minp < prio && dim < limit)
						r.kind = sltks_pkg::KIND_REPLACED;
					else
						r.kind = sltks_pkg::KIND_DIM;
				end
				if (r.kind != sltks_pkg::KIND_DIM) begin
					tbl_id[dim] = b.id;
					tbl_prio[dim] = prio;
					tbl_fall[dim] = fall[17:0];
					slot_written[dim] = 1'b1;
					r.slot = dim[2:0];
					r.id = b.id;
					r.prio = prio;
					r.fall = fall[17:0];
				end
			end
		end
		r.total = tbl_count[3:0];
		return r;
	endfunction

	task automatic queue_beat(light_beat_t b);
		expected_results.push_back(predict_light_result(b));
		pending_beats.push_back(b);
	endtask

	function automatic light_beat_t blank_beat(logic [1:0] cmd);
		light_beat_t b;
		b = '{cmd: cmd, id: $urandom, px: $urandom, py: $urandom, pz: $urandom,
			radius: 31'($urandom_range(1, 32'h7FFF_FFFF)), bright: 16'($urandom),
			enabled: 1'b1, owner: $urandom, no_self: 1'($urandom), visited: 1'b0,
			sel: 3'($urandom)};
		return b;
	endfunction

	// Offer placed near the query sphere so most of them overlap.
	function automatic light_beat_t near_offer();
		light_beat_t b;
		int unsigned span;
		b = blank_beat(sltks_pkg::CMD_OFFER);
		b.radius = ($urandom_range(0, 9) == 0) ? 31'($urandom_range(1, 32'h7FFF_FFFF))
			: 31'($urandom_range(1, 1 << $urandom_range(4, 22)));
		span = b.radius > 32'h3FFF_FFFF ? 32'h3FFF_FFFF : b.radius;
		b.px = q_x + ($urandom_range(0, 2 * span) - span);
		b.py = q_y + ($urandom_range(0, 2 * span) - span);
		b.pz = q_z + ($urandom_range(0, 2 * span) - span);
		if ($urandom_range(0, 3) == 0) b.bright = 16'($urandom_range(0, 255));
		if ($urandom_range(0, 19) == 0) b.enabled = 1'b0;
		if ($urandom_range(0, 19) == 0) b.visited = 1'b1;
		if ($urandom_range(0, 14) == 0) b.owner = q_obj;
		return b;
	endfunction

	task automatic queue_read();
		light_beat_t b;
		b = blank_beat(sltks_pkg::CMD_READ);
		if (slot_written == '0) begin
			queue_beat(near_offer());
		end else begin
			while (!slot_written[b.sel]) b.sel = 3'($urandom);
			queue_beat(b);
		end
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_addr  <= addr;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (addr)
			sltks_pkg::REG_QUERY_X:      q_x = data;
			sltks_pkg::REG_QUERY_Y:      q_y = data;
			sltks_pkg::REG_QUERY_Z:      q_z = data;
			sltks_pkg::REG_QUERY_RADIUS: q_rad = data[30:0];
			sltks_pkg::REG_QUERY_OBJECT: q_obj = data;
			sltks_pkg::REG_MAX_SLOTS:    q_slots = data[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		wait (pending_beats.size() == 0 && expected_results.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// fill process
	initial begin
		light_beat_t b;
		logic [31:0] pick;
		q_x = '0; q_y = '0; q_z = '0; q_rad = '0; q_obj = '0; q_slots = 4'd8;
		tbl_count = 0;
		slot_written = '0;
		for (int i = 0; i < sltks_pkg::MAX_SLOTS; i++) begin
			tbl_id[i] = '0; tbl_prio[i] = '0; tbl_fall[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: center of the query at the origin, full table of eight
		write_reg(sltks_pkg::REG_QUERY_RADIUS, 32'h0001_0000);
		write_reg(sltks_pkg::REG_QUERY_OBJECT, 32'hA5A5_0001);
		queue_beat(blank_beat(sltks_pkg::CMD_CLEAR));
		b = blank_beat(sltks_pkg::CMD_OFFER); b.enabled = 1'b0; queue_beat(b);   // disabled
		b = blank_beat(sltks_pkg::CMD_OFFER); b.visited = 1'b1; queue_beat(b);   // visited
		b = blank_beat(sltks_pkg::CMD_OFFER); b.owner = q_obj; b.no_self = 1'b1; // self light
		b.px = 0; b.py = 0; b.pz = 0; queue_beat(b);
		b = blank_beat(CMD_BAD); queue_beat(b);                                   // unknown cmd
		b = blank_beat(sltks_pkg::CMD_OFFER); b.px = 32'h8000_0000; b.py = 32'h8000_0000;
		b.pz = 32'h8000_0000; b.radius = 31'd1; queue_beat(b);                   // far away
		b = blank_beat(sltks_pkg::CMD_OFFER); b.owner = q_obj; b.no_self = 1'b0; // own, allowed
		b.px = 0; b.py = 0; b.pz = 0; b.bright = 16'hFFFF; queue_beat(b);        // falloff one
		b = blank_beat(sltks_pkg::CMD_OFFER); b.px = 32'h7FFF_FFFF; b.py = 0; b.pz = 0;
		b.radius = 31'h7FFF_FFFF; b.bright = 16'hFFFF; queue_beat(b);            // max radius
		b = blank_beat(sltks_pkg::CMD_OFFER); b.px = 32'h0001_0000; b.py = 0; b.pz = 0;
		b.radius = 31'd1; queue_beat(b);                                          // falloff floor
		b = blank_beat(sltks_pkg::CMD_OFFER); b.px = 0; b.py = 32'hFFFF_8000; b.pz = 0;
		b.radius = 31'h0001_0000; b.bright = 16'h1000; queue_beat(b);            // mid falloff
		repeat (5) queue_beat(near_offer());
		b = blank_beat(sltks_pkg::CMD_OFFER); b.px = 0; b.py = 0; b.pz = 0; b.bright = 0;
		b.radius = 31'h0001_0000; queue_beat(b);                                  // zero brightness, full table
		b = blank_beat(sltks_pkg::CMD_OFFER); b.px = 0; b.py = 0; b.pz = 0;
		b.bright = 16'hFFFF; b.radius = 31'h0001_0000; queue_beat(b);            // evicts
		for (int i = 0; i < sltks_pkg::MAX_SLOTS; i++) begin
			b = blank_beat(sltks_pkg::CMD_READ); b.sel = 3'(i); queue_beat(b);
		end
		wait_drained();

		// random phases, each with fresh query regs
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(sltks_pkg::REG_QUERY_X,
				ph == 1 ? 32'h7FFF_FFFF : ph == 2 ? 32'h8000_0000 : $urandom);
			write_reg(sltks_pkg::REG_QUERY_Y,
				ph == 1 ? 32'h7FFF_FFFF : ph == 2 ? 32'h8000_0000 : $urandom);
			write_reg(sltks_pkg::REG_QUERY_Z,
				ph == 1 ? 32'h7FFF_FFFF : ph == 2 ? 32'h8000_0000 : $urandom);
			pick = ph == 3 ? 32'h7FFF_FFFF : ph == 4 ? 32'h0 : $urandom;
			if (ph > 4) pick = pick & ((32'h1 << $urandom_range(8, 31)) - 1);
			write_reg(sltks_pkg::REG_QUERY_RADIUS, pick);
			write_reg(sltks_pkg::REG_QUERY_OBJECT, $urandom);
			case (ph)
				0: pick = 0;
				1: pick = 15;
				2: pick = 1;
				3: pick = 8;
				default: pick = {$urandom_range(0, 1) ? 28'h0 : 28'hFFFF_FFF,
					4'($urandom_range(0, 15))};
			endcase
			write_reg(sltks_pkg::REG_MAX_SLOTS, pick);
			if (ph == 6) long_stall_go = 1'b1;
			if ($urandom_range(0, 1)) queue_beat(blank_beat(sltks_pkg::CMD_CLEAR));
			for (int n = 0; n < 140; n++) begin
				case ($urandom_range(0, 99)) inside
					[0:69]:  queue_beat(near_offer());
					[70:77]: begin
						b = blank_beat(sltks_pkg::CMD_OFFER);
						b.enabled = 1'($urandom); b.visited = 1'($urandom);
						queue_beat(b);
					end
					[78:91]: queue_read();
					[92:95]: queue_beat(blank_beat(sltks_pkg::CMD_CLEAR));
					default: queue_beat(blank_beat(CMD_BAD));
				endcase
			end
			wait_drained();
		end

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// driver: bursts of beats, random gaps between them
	bit in_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) in_taken <= s_axis_tvalid && s_axis_tready;

	always @(negedge clk) begin
		light_beat_t b;
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_beats.size() != 0) begin
				b = pending_beats.pop_front();
				s_axis_tuser <= b.cmd;
				s_axis_tdata <= {3'b0, b.sel, b.visited, b.no_self, b.owner, b.enabled,
					b.bright, b.radius, b.pz, b.py, b.px, b.id};
				s_axis_tvalid <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stall modes; one long hold-off
	int rx_phase = 0;
	int rx_mode = 0;
	int long_stall_left = 0;
	bit long_stall_done = 1'b0;
	always @(negedge clk) begin
		rx_phase++;
		if (rx_phase % 64 == 0) rx_mode = $urandom_range(0, 3);
		if (long_stall_go && !long_stall_done) begin
			long_stall_done = 1'b1;
			long_stall_left = 400;
		end
		if (long_stall_left > 0) begin
			long_stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= (rx_phase % 4) == 0;
				default: m_axis_tready <= $urandom_range(0, 7) != 0;
			endcase
		end
	end

	task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("mismatch %0t: %s got %h want %h", $realtime, field, got, want);
	endtask

	// monitor: result beats against the oldest expectation
	always @(posedge clk) begin
		light_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				flag_mismatch("unexpected beat", 32'(m_axis_tuser), '0);
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tuser != want.kind)
					flag_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
				if (m_axis_tdata[2:0] != want.slot)
					flag_mismatch("slot", 32'(m_axis_tdata[2:0]), 32'(want.slot));
				if (m_axis_tdata[6:3] != want.total)
					flag_mismatch("total", 32'(m_axis_tdata[6:3]), 32'(want.total));
				if (m_axis_tdata[38:7] != want.id)
					flag_mismatch("light id", m_axis_tdata[38:7], want.id);
				if (m_axis_tdata[70:39] != want.prio)
					flag_mismatch("priority", m_axis_tdata[70:39], want.prio);
				if (m_axis_tdata[88:71] != want.fall)
					flag_mismatch("falloff", 32'(m_axis_tdata[88:71]), 32'(want.fall));
			end
		end
	end

	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule
